[hw/rtl/lar_pkg.sv]
`timescale 1ns / 1ps

package lar_pkg;

    // Item field widths
    localparam int COUNT_W = 16;
    localparam int GAIN_W  = 3;
    localparam int TIME_W  = 2;
    localparam int CONV_W  = 4;
    localparam int LUX_W   = 17;
    localparam int STAT_W  = 2;
    localparam int ROM_W   = 25;
    localparam int FRAC_W  = 8;
    localparam int IDX_W   = 8;

    // Numerator of the normalization: count in 16.8 fixed point
    localparam int QUO_W   = COUNT_W + FRAC_W;
    localparam int DIVS_W  = CONV_W + 1;
    localparam int STEP_W  = $clog2(QUO_W);

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam int TABLE_ENTRIES_DEF = 132;
    localparam int ROM_DEPTH         = 132;

    localparam logic [GAIN_W-1:0] GAIN_MAX = 3'd4;
    localparam logic [TIME_W-1:0] TIME_MAX = 2'd3;
    localparam logic [CONV_W-1:0] CONV_MAX = 4'd15;
    localparam logic [TIME_W-1:0] TIME_RST = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_FULL = 16'hffff;
    localparam int FULL_W = DIVS_W + 10 + 2 * TIME_W + 1;

    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NOT_READY = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_SATURATED = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_OVERFLOW  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_AUTORANGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PD_DOUBLE = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_LOOKUP,
        ST_INTERP,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic                operation;
        logic [COUNT_W-1:0]  raw_count;
        logic                ready_flag;
        logic                analog_saturated;
        logic                comparator_saturated;
        logic [GAIN_W-1:0]   new_gain_step;
        logic [TIME_W-1:0]   new_time_step;
        logic [CONV_W-1:0]   new_conv_count;
    } item_t;

    typedef struct packed {
        logic [LUX_W-1:0]  lux_value;
        logic [STAT_W-1:0] status_code;
        logic [GAIN_W-1:0] gain_step_now;
        logic [TIME_W-1:0] time_step_now;
        logic [CONV_W-1:0] conv_count_now;
    } result_t;

    typedef struct packed {
        logic capture;
        logic div_step;
        logic lookup;
        logic interp;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic bypass;
    } dp_stat_t;

    // lux * 256 at each integer step of the normalized count
    localparam logic [ROM_W-1:0] LUX_ROM [ROM_DEPTH] = '{
        25'd0,        25'd122438,   25'd244941,   25'd367571,   25'd490392,
        25'd613470,   25'd736866,   25'd860645,   25'd984869,   25'd1109602,
        25'd1234906,  25'd1360843,  25'd1487476,  25'd1614866,  25'd1743074,
        25'd1872160,  25'd2002185,  25'd2133209,  25'd2265290,  25'd2398487,
        25'd2532857,  25'd2668458,  25'd2805345,  25'd2943575,  25'd3083201,
        25'd3224279,  25'd3366860,  25'd3510997,  25'd3656742,  25'd3804143,
        25'd3953251,  25'd4104114,  25'd4256778,  25'd4411289,  25'd4567692,
        25'd4726031,  25'd4886347,  25'd5048682,  25'd5213076,  25'd5379566,
        25'd5548189,  25'd5718982,  25'd5891978,  25'd6067209,  25'd6244707,
        25'd6424501,  25'd6606619,  25'd6791087,  25'd6977929,  25'd7167169,
        25'd7358827,  25'd7552923,  25'd7749474,  25'd7948496,  25'd8150002,
        25'd8354004,  25'd8560513,  25'd8769534,  25'd8981075,  25'd9195140,
        25'd9411728,  25'd9630841,  25'd9852474,  25'd10076624, 25'd10303283,
        25'd10532440, 25'd10764085, 25'd10998203, 25'd11234777, 25'd11473788,
        25'd11715214, 25'd11959032, 25'd12205214, 25'd12453731, 25'd12704552,
        25'd12957642, 25'd13212962, 25'd13470475, 25'd13730135, 25'd13991899,
        25'd14255718, 25'd14521539, 25'd14789310, 25'd15058972, 25'd15330466,
        25'd15603728, 25'd15878692, 25'd16155289, 25'd16433445, 25'd16713087,
        25'd16994133, 25'd17276503, 25'd17560111, 25'd17844868, 25'd18130682,
        25'd18417457, 25'd18705095, 25'd18993492, 25'd19282544, 25'd19572141,
        25'd19862170, 25'd20152513, 25'd20443051, 25'd20733660, 25'd21024212,
        25'd21314576, 25'd21604616, 25'd21894194, 25'd22183166, 25'd22471385,
        25'd22758701, 25'd23044960, 25'd23330001, 25'd23613663, 25'd23895778,
        25'd24176175, 25'd24454680, 25'd24731113, 25'd25005290, 25'd25277023,
        25'd25546121, 25'd25812386, 25'd26075617, 25'd26335611, 25'd26592155,
        25'd26845037, 25'd27094038, 25'd27338933, 25'd27579496, 25'd27815494,
        25'd28046689, 25'd28272839
    };

    // Entries past the end of the curve read as zero
    function automatic logic [ROM_W-1:0] lux_rom_read(input logic [IDX_W-1:0] idx);
        logic [ROM_W-1:0] val;
        val = '0;
        if (int'(idx) < ROM_DEPTH)
        begin
            val = LUX_ROM[idx];
        end
        return val;
    endfunction

endpackage

[hw/rtl/lar_ctrl.sv]
`timescale 1ns / 1ps

module lar_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               out_free,
    input  lar_pkg::dp_stat_t  stat,
    output lar_pkg::dp_cmd_t   cmd
);
    import lar_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    step_next   = '0;
                    state_next  = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                // load items and unready readings skip the arithmetic
                if (stat.bypass)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (step_reg == STEP_W'(QUO_W - 1))
                    begin
                        state_next = ST_LOOKUP;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_INTERP;
            end
            ST_INTERP:
            begin
                cmd.interp = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                // hold until the output register can take the item
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/lar_datapath.sv]
`timescale 1ns / 1ps

module lar_datapath #(
    parameter int TABLE_ENTRIES = lar_pkg::TABLE_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lar_pkg::item_t     item_in,
    input  logic               autorange_enable,
    input  logic               photodiode_double,
    input  lar_pkg::dp_cmd_t   cmd,
    output lar_pkg::dp_stat_t  stat,
    output lar_pkg::result_t   result
);
    import lar_pkg::*;

    localparam int LAST = TABLE_ENTRIES - 2;

    logic [GAIN_W-1:0]  gain_reg;
    logic [GAIN_W-1:0]  gain_next;
    logic [TIME_W-1:0]  time_reg;
    logic [TIME_W-1:0]  time_next;
    logic [CONV_W-1:0]  conv_reg;
    logic [CONV_W-1:0]  conv_next;

    item_t              item_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [DIVS_W-1:0]  rem_reg;
    logic [ROM_W-1:0]   y1_reg;
    logic [ROM_W-1:0]   y2_reg;
    logic [FRAC_W-1:0]  frac_reg;
    logic [LUX_W-1:0]   lux_reg;

    logic [3:0]         shamt;
    logic [QUO_W-1:0]   numer;
    logic [DIVS_W-1:0]  divisor;
    logic [DIVS_W:0]    trial;
    logic               trial_ge;
    logic [COUNT_W-1:0] q_int;
    logic [IDX_W-1:0]   x1;
    logic [ROM_W-1:0]   diff;
    logic [ROM_W+FRAC_W-1:0] prod;
    logic [ROM_W-1:0]   dy;
    logic [ROM_W-1:0]   interp_sum;

    logic [FULL_W-1:0]  full_cnt;
    logic [FULL_W-1:0]  full_m1;
    logic [COUNT_W-1:0] fs_count;
    logic [COUNT_W-1:0] max_eighth;
    logic               sat;
    logic               go_down;
    logic               go_up;
    logic [STAT_W-1:0]  status;

    assign divisor = DIVS_W'(conv_reg) + 1'b1;
    assign shamt   = 4'({gain_reg, 1'b0}) + 4'(photodiode_double) + 4'({time_reg, 1'b0});
    assign numer   = {item_in.raw_count, {FRAC_W{1'b0}}} >> shamt;

    // one quotient bit per cycle; the divisor is 1 to 16
    assign trial    = {rem_reg, quo_reg[QUO_W-1]};
    assign trial_ge = trial >= {1'b0, divisor};

    assign q_int = quo_reg[QUO_W-1:FRAC_W];
    assign x1    = (q_int > COUNT_W'(LAST)) ? IDX_W'(LAST) : q_int[IDX_W-1:0];

    assign diff       = y2_reg - y1_reg;
    assign prod       = diff * frac_reg;
    assign dy         = (y2_reg >= y1_reg) ? prod[ROM_W+FRAC_W-1:FRAC_W] : '0;
    assign interp_sum = y1_reg + dy;

    // full scale from the settings in force before this item
    assign full_cnt   = FULL_W'({divisor, 10'b0}) << {time_reg, 1'b0};
    assign full_m1    = full_cnt - 1'b1;
    assign fs_count   = (full_m1 > FULL_W'(COUNT_FULL)) ? COUNT_FULL
                                                        : full_m1[COUNT_W-1:0];
    assign max_eighth = fs_count >> 3;

    assign sat = item_reg.analog_saturated | item_reg.comparator_saturated;

    assign go_down = sat || (item_reg.raw_count > (fs_count - max_eighth));
    assign go_up   = !go_down && (item_reg.raw_count < max_eighth);

    assign stat.bypass = item_reg.operation | ~item_reg.ready_flag;

    always_comb
    begin
        if (item_reg.operation)
        begin
            status = STATUS_OK;
        end
        else if (!item_reg.ready_flag)
        begin
            status = STATUS_NOT_READY;
        end
        else if (sat)
        begin
            status = STATUS_SATURATED;
        end
        else if (item_reg.raw_count >= fs_count)
        begin
            status = STATUS_OVERFLOW;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    always_comb
    begin
        gain_next = gain_reg;
        time_next = time_reg;
        conv_next = conv_reg;
        if (item_reg.operation)
        begin
            gain_next = (item_reg.new_gain_step > GAIN_MAX) ? GAIN_MAX
                                                             : item_reg.new_gain_step;
            time_next = item_reg.new_time_step;
            conv_next = item_reg.new_conv_count;
        end
        else if (item_reg.ready_flag && autorange_enable)
        begin
            if (go_down)
            begin
                if (conv_reg != '0)
                begin
                    conv_next = conv_reg - 1'b1;
                end
                else if (time_reg != '0)
                begin
                    time_next = time_reg - 1'b1;
                    conv_next = '0;
                end
                else if (gain_reg != '0)
                begin
                    gain_next = gain_reg - 1'b1;
                end
            end
            else if (go_up)
            begin
                if (gain_reg < GAIN_MAX)
                begin
                    gain_next = gain_reg + 1'b1;
                end
                else if (time_reg < TIME_MAX)
                begin
                    time_next = time_reg + 1'b1;
                    conv_next = '0;
                end
                else if (conv_reg < CONV_MAX)
                begin
                    conv_next = conv_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        result.lux_value      = (stat.bypass || status != STATUS_OK) ? '0 : lux_reg;
        result.status_code    = status;
        result.gain_step_now  = gain_next;
        result.time_step_now  = time_next;
        result.conv_count_now = conv_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
            time_reg <= TIME_RST;
            conv_reg <= '0;
        end
        else if (cmd.finish)
        begin
            gain_reg <= gain_next;
            time_reg <= time_next;
            conv_reg <= conv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item_in;
            quo_reg  <= numer;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            if (trial_ge)
            begin
                rem_reg <= DIVS_W'(trial - {1'b0, divisor});
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DIVS_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
        if (cmd.lookup)
        begin
            y1_reg   <= lux_rom_read(x1);
            y2_reg   <= lux_rom_read(x1 + 1'b1);
            frac_reg <= quo_reg[FRAC_W-1:0];
        end
        if (cmd.interp)
        begin
            lux_reg <= interp_sum[ROM_W-1:FRAC_W];
        end
    end

endmodule

[hw/rtl/light_count_to_lux_autorange.sv]
`timescale 1ns / 1ps

// Light-sensor count to lux converter with automatic ranging.
// Input stream s_*: one item per reading or settings load. s_tuser selects
// the kind (0 reading, 1 load); s_tdata carries the count, sensor flags and
// the settings to load. Output stream m_*: one item per input item with lux,
// status in m_tuser and the gain/integration/conversion settings now in use.
// Configuration channel cfg_*: index 0 autorange enable, 1 photodiode
// doubling; always ready, write only while no item is in flight.
// A reading passes from acceptance to m_tvalid through one-bit-per-cycle
// division by the conversion count plus one, then a ROM lookup, an
// interpolation and the result state. Load items and unready readings
// skip the division, lookup and interpolation. One item is processed at a
// time; the next is accepted the cycle after the result moves to the
// output register.
// When m_tready is low the result stays in the output register; the next
// item is still accepted and worked on, and waits for the register to free.
// Reset clears the settings to gain 1x, 64 time units, conversion count 0,
// and both configuration bits to 0.
module light_count_to_lux_autorange #(
    parameter int TABLE_ENTRIES = lar_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] raw_count, [16] ready_flag, [17] analog_saturated,
    // [18] comparator_saturated, [21:19] new_gain_step,
    // [23:22] new_time_step, [27:24] new_conv_count, [31:28] zero
    input  logic [lar_pkg::S_TDATA_W-1:0]      s_tdata,
    // [0] operation
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [16:0] lux_value, [19:17] gain_step_now, [21:20] time_step_now,
    // [25:22] conv_count_now, [31:26] zero
    output logic [lar_pkg::M_TDATA_W-1:0]      m_tdata,
    // [1:0] status_code
    output logic [lar_pkg::STAT_W-1:0]         m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lar_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic                               cfg_data
);
    import lar_pkg::*;

    logic      autorange_reg;
    logic      pd_double_reg;
    logic      m_valid_reg;
    result_t   out_reg;
    item_t     item_in;
    result_t   result;
    dp_cmd_t   cmd;
    dp_stat_t  stat;
    logic      out_free;

    assign item_in.operation            = s_tuser;
    assign item_in.raw_count            = s_tdata[15:0];
    assign item_in.ready_flag           = s_tdata[16];
    assign item_in.analog_saturated     = s_tdata[17];
    assign item_in.comparator_saturated = s_tdata[18];
    assign item_in.new_gain_step        = s_tdata[21:19];
    assign item_in.new_time_step        = s_tdata[23:22];
    assign item_in.new_conv_count       = s_tdata[27:24];

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            autorange_reg <= 1'b0;
            pd_double_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_AUTORANGE)
            begin
                autorange_reg <= cfg_data;
            end
            else if (cfg_index == CFG_PD_DOUBLE)
            begin
                pd_double_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.status_code;
    assign m_tdata  = {6'b0, out_reg.conv_count_now, out_reg.time_step_now,
                       out_reg.gain_step_now, out_reg.lux_value};

    lar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    lar_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_in           (item_in),
        .autorange_enable  (autorange_reg),
        .photodiode_double (pd_double_reg),
        .cmd               (cmd),
        .stat              (stat),
        .result            (result)
    );

endmodule

[hw/rtl/lar_checker.sv]
`timescale 1ns / 1ps

module lar_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [lar_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic [lar_pkg::STAT_W-1:0]         m_tuser
);
    import lar_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    // one item in flight: no acceptance right after another
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    a_lux_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != STATUS_OK |-> m_tdata[16:0] == '0)
        else $error("lux nonzero with error status");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[19:17] <= GAIN_MAX)
        else $error("reported gain step out of range");

endmodule

bind light_count_to_lux_autorange lar_checker u_lar_checker (.*);
